// ----- hdl/bps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the buzzer pattern sequencer
// holds the pattern tables, the command and result formats and the
// register map
// ----------------------------------------------------------------------------
package bps_pkg;

	// request queue
	localparam int QUEUE_DEPTH_DEF = 10;

	// configuration register map
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int LEN_W       = 16;
	localparam int REG_IDX_W   = 2;
	localparam logic [REG_IDX_W-1:0] REG_LONG_ON = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MEDIUM  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHORT   = 2'd2;

	localparam logic [LEN_W-1:0] LONG_ON_RST = 16'd2000;
	localparam logic [LEN_W-1:0] MEDIUM_RST  = 16'd300;
	localparam logic [LEN_W-1:0] SHORT_RST   = 16'd100;

	// segment counter
	localparam int SEG_W = 4;

	typedef enum logic [1:0] {
		PAT_LONG   = 2'd0,
		PAT_MEDIUM = 2'd1,
		PAT_BATCH  = 2'd2,
		PAT_SETUP  = 2'd3
	} pattern_t;

	typedef enum logic [1:0] {
		LEN_LONG   = 2'd0,
		LEN_MEDIUM = 2'd1,
		LEN_SHORT  = 2'd2
	} len_sel_t;

	typedef struct packed {
		logic     level;
		len_sel_t len_sel;
	} seg_t;

	// classified input item
	typedef struct packed {
		logic     is_enq;
		pattern_t btype;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic buzzer_on;
		logic dropped;
		logic playing;
	} result_t;

	// segment lengths from the registers
	typedef struct packed {
		logic [LEN_W-1:0] long_len;
		logic [LEN_W-1:0] medium_len;
		logic [LEN_W-1:0] short_len;
	} cfg_t;

	// request queue control and status
	typedef struct packed {
		logic push;
		logic pop;
	} rq_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rq_stat_t;

	function automatic logic [SEG_W-1:0] pat_len(input pattern_t p);
		logic [SEG_W-1:0] n;
		case (p)
			PAT_LONG:   n = 4'd1;
			PAT_MEDIUM: n = 4'd1;
			PAT_BATCH:  n = 4'd6;
			PAT_SETUP:  n = 4'd12;
			default:    n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic seg_t seg_lookup(input pattern_t p, input logic [SEG_W-1:0] idx);
		seg_t s;
		case (p)
			PAT_LONG:   s = '{level: 1'b1, len_sel: LEN_LONG};
			PAT_MEDIUM: s = '{level: 1'b1, len_sel: LEN_MEDIUM};
			PAT_BATCH: begin
				// medium on, medium off, then short on/off pairs
				s.level   = ~idx[0];
				s.len_sel = (idx < 4'd2) ? LEN_MEDIUM : LEN_SHORT;
			end
			PAT_SETUP: begin
				s.level   = ~idx[0];
				s.len_sel = LEN_SHORT;
			end
			default:    s = '{level: 1'b0, len_sel: LEN_SHORT};
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bps_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bps_front: input side of the sequencer
// takes items off the push port, classifies them and holds them in a
// two-entry queue until the back end takes them
// ----------------------------------------------------------------------------
module bps_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic          req_type,
	input  wire logic [1:0]    beep_kind,
	output logic               cmd_valid,
	input  wire logic          cmd_ready,
	output bps_pkg::cmd_t      cmd
);
	import bps_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;
	cmd_t       cmd_in;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	// classify: enqueue or tick
	always_comb begin
		cmd_in.is_enq = req_type;
		cmd_in.btype  = pattern_t'(beep_kind);
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= 2'(cnt_q + 2'd1);
				2'b01:   cnt_q <= 2'(cnt_q - 2'd1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/bps_reqq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bps_reqq: queue of waiting beep requests
// circular buffer with a registered head read; the head word is kept
// current, with a bypass when the word is written as it is fetched
// ----------------------------------------------------------------------------
module bps_reqq #(
	parameter int QUEUE_DEPTH = bps_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bps_pkg::rq_ctl_t ctl,
	input  wire bps_pkg::pattern_t wr_data,
	output bps_pkg::rq_stat_t    stat,
	output bps_pkg::pattern_t    head_data
);
	import bps_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pattern_t         mem [QUEUE_DEPTH];
	pattern_t         head_q;
	logic [PTR_W-1:0] head_ptr_q;
	logic [PTR_W-1:0] tail_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] head_ptr_n;
	logic [PTR_W-1:0] tail_ptr_n;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = ctl.push && !stat.full;
	assign do_pop     = ctl.pop && !stat.empty;
	assign head_ptr_n = do_pop ? ptr_inc(head_ptr_q) : head_ptr_q;
	assign tail_ptr_n = do_push ? ptr_inc(tail_ptr_q) : tail_ptr_q;
	assign head_data  = head_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_ptr_q] <= wr_data;
		end
		// keep the head word current
		if (do_push && (tail_ptr_q == head_ptr_n)) begin
			head_q <= wr_data;
		end else begin
			head_q <= mem[head_ptr_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
			cnt_q      <= '0;
		end else begin
			head_ptr_q <= head_ptr_n;
			tail_ptr_q <= tail_ptr_n;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/bps_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bps_back: pattern engine and result queue
// executes one command a cycle while the result queue has room, against the
// request queue and the segment counter, and queues the result in a two-entry buffer
// ----------------------------------------------------------------------------
module bps_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bps_pkg::cfg_t        cfg,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire bps_pkg::cmd_t        cmd,
	output bps_pkg::rq_ctl_t          rq_ctl,
	input  wire bps_pkg::rq_stat_t    rq_stat,
	input  wire bps_pkg::pattern_t    rq_head,
	output logic                      empty,
	input  wire logic                 pop,
	output bps_pkg::result_t          res
);
	import bps_pkg::*;

	// sequencer state
	pattern_t         pat_q;
	logic [SEG_W-1:0] idx_q;
	logic [LEN_W-1:0] ticks_q;
	logic             level_q;
	logic             active_q;

	pattern_t         pat_n;
	logic [SEG_W-1:0] idx_n;
	logic [LEN_W-1:0] ticks_n;
	logic             level_n;
	logic             active_n;
	logic             dropped;
	logic             do_load;
	seg_t             seg;
	logic             go;

	// result queue
	result_t          oq_q [2];
	logic             oq_wr_q;
	logic             oq_rd_q;
	logic [1:0]       oq_cnt_q;
	logic             oq_full;
	logic             oq_pop;

	assign oq_full   = (oq_cnt_q == 2'd2);
	assign cmd_ready = !oq_full;
	assign go        = cmd_valid && !oq_full;
	assign empty     = (oq_cnt_q == 2'd0);
	assign oq_pop    = pop && !empty;
	assign res       = oq_q[oq_rd_q];

	always_comb begin
		pat_n     = pat_q;
		idx_n     = idx_q;
		ticks_n   = ticks_q;
		level_n   = level_q;
		active_n  = active_q;
		dropped   = 1'b0;
		do_load   = 1'b0;
		rq_ctl    = '{push: 1'b0, pop: 1'b0};
		if (cmd.is_enq) begin
			if (rq_stat.full) begin
				dropped = 1'b1;
			end else begin
				rq_ctl.push = go;
			end
		end else if (!rq_stat.empty) begin
			// a waiting request preempts the running pattern
			rq_ctl.pop = go;
			pat_n      = rq_head;
			idx_n      = '0;
			do_load    = 1'b1;
		end else if (active_q) begin
			if (ticks_q <= 16'd1) begin
				idx_n   = SEG_W'(idx_q + 1'b1);
				do_load = 1'b1;
			end else begin
				ticks_n = LEN_W'(ticks_q - 1'b1);
			end
		end

		seg = seg_lookup(pat_n, idx_n);
		if (do_load) begin
			if (idx_n >= pat_len(pat_n)) begin
				active_n = 1'b0;
				level_n  = 1'b0;
				ticks_n  = '0;
				idx_n    = '0;
			end else begin
				active_n = 1'b1;
				level_n  = seg.level;
				case (seg.len_sel)
					LEN_LONG:   ticks_n = cfg.long_len;
					LEN_MEDIUM: ticks_n = cfg.medium_len;
					default:    ticks_n = cfg.short_len;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q    <= PAT_LONG;
			idx_q    <= '0;
			ticks_q  <= '0;
			level_q  <= 1'b0;
			active_q <= 1'b0;
		end else if (go) begin
			pat_q    <= pat_n;
			idx_q    <= idx_n;
			ticks_q  <= ticks_n;
			level_q  <= level_n;
			active_q <= active_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			oq_q[oq_wr_q] <= '{buzzer_on: level_n, dropped: dropped, playing: active_n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (go) begin
				oq_wr_q <= ~oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= ~oq_rd_q;
			end
			case ({go, oq_pop})
				2'b10:   oq_cnt_q <= 2'(oq_cnt_q + 2'd1);
				2'b01:   oq_cnt_q <= 2'(oq_cnt_q - 2'd1);
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/buzzer_pattern_sequencer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_core: buzzer pattern sequencer
// ticks and beep requests in, buzzer level and status out; requests wait
// in a queue and start their pattern on the next tick
// ----------------------------------------------------------------------------
//
// channel   handshake           payload
// -------   -----------------   ---------------------------------------
// input     push / full         req_type, beep_kind
// result    pop / empty         buzzer_on, dropped, playing
// config    psel/penable/pready paddr, pwdata, prdata (16-bit lengths)
//
// - one item per cycle sustained while results are taken; each item is
//   registered in the front queue and then, as its result, in the result
//   queue before its result can be taken
// - the pattern engine updates its state once for each item it executes
// - reset clears both queues, the request queue and the pattern state, and
//   loads the segment lengths with their defaults; no clearing pass
// - a stalled result side fills the two-entry result queue, then the
//   two-entry front queue, and only then raises full
//
module buzzer_pattern_sequencer_core #(
	parameter int QUEUE_DEPTH = bps_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bps_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [bps_pkg::DATA_W-1:0]  pwdata,
	output logic      [bps_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	// input items
	input  wire logic                        push,
	output logic                             full,
	input  wire logic                        req_type,
	input  wire logic [1:0]                  beep_kind,
	// results
	output logic                             empty,
	input  wire logic                        pop,
	output logic                             buzzer_on,
	output logic                             dropped,
	output logic                             playing
);
	import bps_pkg::*;

	cfg_t             cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic             cfg_wr;

	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;
	rq_ctl_t          rq_ctl;
	rq_stat_t         rq_stat;
	pattern_t         rq_head;
	result_t          res;

	// register file, written in the access phase of a transfer
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_len   <= LONG_ON_RST;
			cfg_q.medium_len <= MEDIUM_RST;
			cfg_q.short_len  <= SHORT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LONG_ON: cfg_q.long_len   <= pwdata[LEN_W-1:0];
				REG_MEDIUM:  cfg_q.medium_len <= pwdata[LEN_W-1:0];
				REG_SHORT:   cfg_q.short_len  <= pwdata[LEN_W-1:0];
				default:     cfg_q            <= cfg_q;  // unmapped address
			endcase
		end
	end

	// read back, unmapped addresses read zero
	always_comb begin
		case (reg_idx)
			REG_LONG_ON: prdata = DATA_W'(cfg_q.long_len);
			REG_MEDIUM:  prdata = DATA_W'(cfg_q.medium_len);
			REG_SHORT:   prdata = DATA_W'(cfg_q.short_len);
			default:     prdata = '0;
		endcase
	end

	// front: accept and classify
	bps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.beep_kind (beep_kind),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// queue of waiting beep requests
	bps_reqq #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_reqq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rq_ctl),
		.wr_data   (cmd.btype),
		.stat      (rq_stat),
		.head_data (rq_head)
	);

	// back: pattern engine and result queue
	bps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rq_ctl    (rq_ctl),
		.rq_stat   (rq_stat),
		.rq_head   (rq_head),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign buzzer_on = res.buzzer_on;
	assign dropped   = res.dropped;
	assign playing   = res.playing;

endmodule
`default_nettype wire

// ----- verif/buzzer_pattern_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_core_tb: self-checking bench for the sequencer
// drives ticks and beep requests through the push/full side, takes results
// at random through pop/empty, predicts each result with a local model of
// the request queue and the pattern engine, and reprograms the segment
// lengths over apb between phases
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer_core_tb;
	import bps_pkg::*;

	localparam int QDEPTH          = QUEUE_DEPTH_DEF;
	// cycles without any transfer before the run is declared hung; the worst
	// correct gap is a random pop stall or a drain between phases, far below
	localparam int STALL_LIMIT     = 2000;
	// results are registered in the front queue, then in the result queue, after their transfer
	localparam int TAIL_CYCLES     = 20;
	localparam int ITEMS_PER_PHASE = 230;
	// keep tick runs short when the segment lengths are huge
	localparam int SPAN_CAP        = 60;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_ENQ  = 1'b1;

	// dut ports
	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              push      = 1'b0;
	logic              full;
	logic              req_type  = 1'b0;
	logic [1:0]        beep_kind = 2'd0;
	logic              empty;
	logic              pop       = 1'b0;
	logic              buzzer_on;
	logic              dropped;
	logic              playing;

	buzzer_pattern_sequencer_core #(
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.beep_kind(beep_kind),
		.empty    (empty),
		.pop      (pop),
		.buzzer_on(buzzer_on),
		.dropped  (dropped),
		.playing  (playing)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one input item waiting for the driver
	typedef struct {
		logic       is_enq;
		logic [1:0] btype;
		bit         hold;   // go out only once every earlier result is back
	} beep_item_t;

	beep_item_t pending_items[$];
	result_t    expected_results[$];

	int sent_n      = 0;
	int got_n       = 0;
	int idle_cycles = 0;
	int errors      = 0;
	bit calm        = 1'b0;   // no idling on either side
	bit timed_out   = 1'b0;
	int gen_count;
	int gen_hold_at;

	// ------------------------------------------------------------------------
	// local model of the sequencer
	// ------------------------------------------------------------------------

	// segment lengths as programmed
	logic [LEN_W-1:0] long_len;
	logic [LEN_W-1:0] medium_len;
	logic [LEN_W-1:0] short_len;

	// request queue
	pattern_t req_mem [QDEPTH];
	int       req_head;
	int       req_count;

	// pattern engine
	pattern_t         cur_pat;
	int               seg_idx;
	logic [LEN_W-1:0] ticks_rem;
	logic             level;
	logic             busy;

	function automatic void reset_buzzer_model();
		long_len   = LONG_ON_RST;
		medium_len = MEDIUM_RST;
		short_len  = SHORT_RST;
		req_head   = 0;
		req_count  = 0;
		cur_pat    = PAT_LONG;
		seg_idx    = 0;
		ticks_rem  = '0;
		level      = 1'b0;
		busy       = 1'b0;
	endfunction

	function automatic int seg_total(input pattern_t p);
		case (p)
			PAT_BATCH: return 6;
			PAT_SETUP: return 12;
			default:   return 1;
		endcase
	endfunction

	// batch opens with two medium segments, everything else short or fixed
	function automatic logic [LEN_W-1:0] seg_ticks(input pattern_t p, input int idx);
		case (p)
			PAT_LONG:   return long_len;
			PAT_MEDIUM: return medium_len;
			PAT_BATCH:  return (idx < 2) ? medium_len : short_len;
			default:    return short_len;
		endcase
	endfunction

	// every pattern starts with the buzzer on and alternates from there
	function automatic void start_segment();
		if (seg_idx >= seg_total(cur_pat)) begin
			busy      = 1'b0;
			level     = 1'b0;
			ticks_rem = '0;
			seg_idx   = 0;
		end else begin
			level     = (seg_idx % 2 == 0);
			ticks_rem = seg_ticks(cur_pat, seg_idx);
			busy      = 1'b1;
		end
	endfunction

	function automatic result_t predict_buzzer(input logic is_enq, input logic [1:0] btype);
		result_t r;
		r.dropped = 1'b0;
		if (is_enq) begin
			// a full queue refuses the request and leaves everything else alone
			if (req_count >= QDEPTH) begin
				r.dropped = 1'b1;
			end else begin
				req_mem[(req_head + req_count) % QDEPTH] = pattern_t'(btype);
				req_count++;
			end
		end else if (req_count > 0) begin
			// a waiting request preempts whatever is playing
			cur_pat  = req_mem[req_head];
			req_head = (req_head + 1) % QDEPTH;
			req_count--;
			seg_idx  = 0;
			start_segment();
		end else if (busy) begin
			// a zero length counts like one
			if (ticks_rem <= 1) begin
				seg_idx++;
				start_segment();
			end else begin
				ticks_rem = ticks_rem - 1'b1;
			end
		end
		r.buzzer_on = level;
		r.playing   = busy;
		return r;
	endfunction

	// ticks a pattern needs to play out under the current lengths
	function automatic int pattern_span(input pattern_t p);
		int total;
		logic [LEN_W-1:0] n;
		total = 0;
		for (int i = 0; i < seg_total(p); i++) begin
			n = seg_ticks(p, i);
			total += (n == 0) ? 1 : n;
		end
		return total;
	endfunction

	// ------------------------------------------------------------------------
	// input side: one transfer per cycle at most, random gaps
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		logic took_in;
		logic took_out;
		logic may_go;
		if (arst_n) begin
			took_in  = push && !full;
			took_out = pop && !empty;
			if (took_in) begin
				expected_results.push_back(predict_buzzer(req_type, beep_kind));
				sent_n <= sent_n + 1;
			end
			if (!push || took_in) begin
				may_go = pending_items.size() != 0 && (calm || $urandom_range(99) >= 24);
				// a held item waits until nothing is outstanding; counted from
				// values before this edge so the monitor's order does not matter
				if (may_go && pending_items[0].hold && (sent_n + took_in != got_n + took_out))
					may_go = 1'b0;
				if (may_go) begin
					push      <= 1'b1;
					req_type  <= pending_items[0].is_enq;
					beep_kind <= pending_items[0].btype;
					void'(pending_items.pop_front());
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result side: random pop, every transfer checked against the model
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				got_n <= got_n + 1;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: buzzer_on=%0b dropped=%0b playing=%0b",
						buzzer_on, dropped, playing);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (buzzer_on !== want.buzzer_on) begin
						$error("buzzer_on: expected %0b, got %0b", want.buzzer_on, buzzer_on);
						errors++;
					end
					if (dropped !== want.dropped) begin
						$error("dropped: expected %0b, got %0b", want.dropped, dropped);
						errors++;
					end
					if (playing !== want.playing) begin
						$error("playing: expected %0b, got %0b", want.playing, playing);
						errors++;
					end
				end
			end
			pop <= calm || ($urandom_range(99) >= 24);
		end
	end

	// watchdog: cycles since the last transfer on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic add_item(input logic is_enq, input logic [1:0] btype);
		beep_item_t it;
		it.is_enq = is_enq;
		it.btype  = btype;
		it.hold   = (gen_count == gen_hold_at);
		pending_items.push_back(it);
		gen_count++;
	endtask

	// beep_kind rides along on ticks with random bits, it must be ignored
	task automatic add_ticks(input int n);
		repeat (n) add_item(REQ_TICK, 2'($urandom_range(3)));
	endtask

	task automatic fill_random(input int n);
		int       kind;
		int       k;
		int       span;
		pattern_t last;
		gen_count   = 0;
		gen_hold_at = n / 2;
		while (gen_count < n) begin
			kind = $urandom_range(99);
			if (kind < 65) begin
				// a few requests, then the ticks that pop and play them
				k = $urandom_range(1, 3);
				last = PAT_LONG;
				repeat (k) begin
					last = pattern_t'($urandom_range(3));
					add_item(REQ_ENQ, last);
				end
				span = (k - 1) + pattern_span(last) + $urandom_range(0, 2);
				// sometimes cut short so the next request preempts mid pattern
				if ($urandom_range(9) < 3)
					span = $urandom_range(1, span);
				add_ticks(span > SPAN_CAP ? SPAN_CAP : span);
			end else if (kind < 77) begin
				// flood the request queue, mostly past full
				repeat ($urandom_range(QDEPTH - 1, QDEPTH + 3))
					add_item(REQ_ENQ, 2'($urandom_range(3)));
				add_ticks($urandom_range(3, 30));
			end else begin
				// noise
				repeat ($urandom_range(1, 6))
					add_item(logic'($urandom_range(1)), 2'($urandom_range(3)));
			end
		end
	endtask

	// apb write: setup cycle, access cycle, register taken at the access edge
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};   // upper half is not part of any register
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_LONG_ON: long_len   = val;
			REG_MEDIUM:  medium_len = val;
			REG_SHORT:   short_len  = val;
			default:     ;
		endcase
	endtask

	task automatic set_lengths(input logic [LEN_W-1:0] l, input logic [LEN_W-1:0] m,
			input logic [LEN_W-1:0] s);
		reg_write(REG_LONG_ON, l);
		reg_write(REG_MEDIUM, m);
		reg_write(REG_SHORT, s);
	endtask

	// all items sent and every result back, or the watchdog fired
	task automatic wait_drained();
		while (!timed_out &&
				(pending_items.size() != 0 || push || expected_results.size() != 0)) begin
			@(negedge clk);
			if (idle_cycles >= STALL_LIMIT)
				timed_out = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [LEN_W-1:0] l;
		logic [LEN_W-1:0] m;
		logic [LEN_W-1:0] s;
		reset_buzzer_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset lengths: fill the queue to the brim, overflow it,
		// then pop with ticks so each new pattern preempts the one before
		gen_count   = 0;
		gen_hold_at = -1;
		add_item(REQ_ENQ, PAT_LONG);
		add_item(REQ_ENQ, PAT_MEDIUM);
		add_item(REQ_ENQ, PAT_BATCH);
		add_item(REQ_ENQ, PAT_SETUP);
		add_item(REQ_ENQ, PAT_SETUP);
		add_item(REQ_ENQ, PAT_MEDIUM);
		add_item(REQ_ENQ, PAT_LONG);
		add_item(REQ_ENQ, PAT_SETUP);
		add_item(REQ_ENQ, PAT_MEDIUM);
		add_item(REQ_ENQ, PAT_BATCH);
		add_item(REQ_ENQ, PAT_SETUP);   // queue full, refused
		add_item(REQ_TICK, 2'd3);
		add_item(REQ_TICK, 2'd0);
		add_item(REQ_TICK, 2'd1);
		add_item(REQ_TICK, 2'd2);
		wait_drained();

		// directed, zero lengths plus a write to the unmapped index: pop the
		// rest, then let the batch pattern run out one tick per segment and
		// finish with a tick while idle and empty
		if (!timed_out) begin
			repeat (4) @(negedge clk);
			set_lengths('0, '0, '0);
			reg_write(REG_UNMAPPED, 16'hffff);
			@(negedge clk);
			add_ticks(6 + 6 + 1);
			wait_drained();
		end

		// random phases over a spread of lengths, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			if (!timed_out) begin
				case (ph)
					0: begin
						l = 1; m = 1; s = 1;
					end
					1: begin
						l = 16'hffff; m = 16'hffff; s = 16'hffff;
					end
					2: begin
						l = 0; m = 0; s = 0;
					end
					3: begin
						l = $urandom_range(1, 6);
						m = $urandom_range(1, 6);
						s = $urandom_range(1, 6);
					end
					4: begin
						l = 16'hffff; m = 1; s = 0;
					end
					default: begin
						l = $urandom_range(2, 12);
						m = $urandom_range(2, 12);
						s = $urandom_range(2, 12);
					end
				endcase
				repeat (4) @(negedge clk);
				set_lengths(l, m, s);
				@(negedge clk);
				calm = (ph == 0);   // one long stretch without gaps
				fill_random(ITEMS_PER_PHASE);
				wait_drained();
			end
		end

		if (!timed_out)
			repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			errors++;
		end
		if (timed_out || errors != 0) begin
			$display("buzzer_pattern_sequencer_core_tb NOT OK");
		end else begin
			$display("buzzer_pattern_sequencer_core_tb OK");
		end
		$finish;
	end

endmodule
